/* hdl/enr_pkg.sv */
// Shared types and constants for the ellipsoid normal and residual block.
// Used by enr_front, enr_sqrt_cell, enr_div_cell and the top level.
package enr_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INV_A = 2'd0,
    REG_INV_B = 2'd1,
    REG_INV_C = 2'd2
  } reg_idx_e;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // results that ride along the pipe next to the normal computation
  typedef struct packed {
    logic [2:0][31:0] grad;
    logic [31:0]      residual;
    logic             sat;
    logic             degen;
    logic [2:0]       neg;
  } side_t;

  // square root cell word
  typedef struct packed {
    logic [63:0]      rad;
    logic [34:0]      rem;
    logic [31:0]      root;
    logic [2:0][30:0] v;
    side_t            side;
  } sqrt_t;

  // division cell word, three components share one divisor
  typedef struct packed {
    logic [31:0]      len;
    logic [2:0][31:0] rem;
    logic [2:0][31:0] numlo;
    logic [2:0][31:0] quo;
    side_t            side;
  } div_t;

endpackage

/* hdl/ellipsoid_normal_and_residual.sv */
// Ellipsoid gradient, implicit residual and unit normal, top level.
// Depends on enr_pkg, enr_front, enr_sqrt_cell and enr_div_cell.
//
// Usage:
// - configuration: cfg_we_i with cfg_idx_i and cfg_data_i writes one of the
//   reciprocal squared semi-axes (0: x, 1: y, 2: z); other indexes are
//   ignored. Write only while no word is in flight.
// - input: a point word is taken at each clock edge with start_i high;
//   busy_o stays low, so one word can enter every cycle.
// - output: done_o marks one cycle in which the gradient, residual, normal
//   and flags are on the result ports. The receiver cannot stall, and the
//   pipe never holds results back.
// - pipeline: a word passes 11 front stages (the first loads at the
//   accepting edge), 32 square root cells, 32 divider cells and one
//   output stage before done_o rises.
// - throughput: one word per cycle, set by the chain of cells, each of which
//   takes a new word every cycle.
// - reset: the configuration registers return to 1.0 and the valid bits
//   clear, so the pipe empties; nothing needs to be swept.
module ellipsoid_normal_and_residual #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] grad_x_o,
  output logic [31:0] grad_y_o,
  output logic [31:0] grad_z_o,
  output logic [31:0] normal_x_o,
  output logic [31:0] normal_y_o,
  output logic [31:0] normal_z_o,
  output logic [31:0] residual_o,
  output logic        saturated_o,
  output logic        degenerate_o
);

  localparam logic [31:0] INV_RESET = 32'd65536;

  logic [31:0] inv_a_q, inv_b_q, inv_c_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_a_q <= INV_RESET;
      inv_b_q <= INV_RESET;
      inv_c_q <= INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        enr_pkg::REG_INV_A: inv_a_q <= cfg_data_i;
        enr_pkg::REG_INV_B: inv_b_q <= cfg_data_i;
        enr_pkg::REG_INV_C: inv_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // front pipeline
  logic           front_vld;
  enr_pkg::sqrt_t front_data;

  enr_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start_i & ~busy_o),
    .pos_i  ({pos_z_i, pos_y_i, pos_x_i}),
    .inv_i  ({inv_c_q, inv_b_q, inv_a_q}),
    .valid_o(front_vld),
    .data_o (front_data)
  );

  // square root chain
  logic           sq_vld  [0:enr_pkg::SQRT_STEPS];
  enr_pkg::sqrt_t sq_data [0:enr_pkg::SQRT_STEPS];

  assign sq_vld[0]  = front_vld;
  assign sq_data[0] = front_data;

  for (genvar k = 0; k < enr_pkg::SQRT_STEPS; k++) begin : g_sqrt
    enr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_vld[k]),
      .data_i (sq_data[k]),
      .valid_o(sq_vld[k+1]),
      .data_o (sq_data[k+1])
    );
  end

  // divider chain, numerator is v shifted up by 30
  logic          dv_vld  [0:enr_pkg::DIV_STEPS];
  enr_pkg::div_t dv_data [0:enr_pkg::DIV_STEPS];

  always_comb begin
    dv_data[0].len  = sq_data[enr_pkg::SQRT_STEPS].root;
    dv_data[0].side = sq_data[enr_pkg::SQRT_STEPS].side;
    dv_data[0].quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_data[0].rem[i]   = {3'd0, sq_data[enr_pkg::SQRT_STEPS].v[i][30:2]};
      dv_data[0].numlo[i] = {sq_data[enr_pkg::SQRT_STEPS].v[i][1:0], 30'd0};
    end
  end
  assign dv_vld[0] = sq_vld[enr_pkg::SQRT_STEPS];

  for (genvar k = 0; k < enr_pkg::DIV_STEPS; k++) begin : g_div
    enr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_vld[k]),
      .data_i (dv_data[k]),
      .valid_o(dv_vld[k+1]),
      .data_o (dv_data[k+1])
    );
  end

  // output stage: sign the normal, force zero for a zero gradient
  enr_pkg::div_t    last;
  logic             done_q;
  logic [2:0][31:0] grad_q;
  logic [2:0][31:0] normal_q;
  logic [31:0]      residual_q;
  logic             sat_q;
  logic             degen_q;

  assign last = dv_data[enr_pkg::DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[enr_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    grad_q     <= last.side.grad;
    residual_q <= last.side.residual;
    sat_q      <= last.side.sat;
    degen_q    <= last.side.degen;
    for (int i = 0; i < 3; i++) begin
      if (last.side.degen) begin
        normal_q[i] <= '0;
      end else if (last.side.neg[i]) begin
        normal_q[i] <= 32'd0 - last.quo[i];
      end else begin
        normal_q[i] <= last.quo[i];
      end
    end
  end

  assign done_o       = done_q;
  assign grad_x_o     = grad_q[0];
  assign grad_y_o     = grad_q[1];
  assign grad_z_o     = grad_q[2];
  assign normal_x_o   = normal_q[0];
  assign normal_y_o   = normal_q[1];
  assign normal_z_o   = normal_q[2];
  assign residual_o   = residual_q;
  assign saturated_o  = sat_q;
  assign degenerate_o = degen_q;

endmodule

/* hdl/enr_front.sv */
// Front pipeline: gradient, residual and normalized gradient magnitudes.
// Depends on enr_pkg; hands a sum of squares to the square root chain.
module enr_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2:0][31:0]    pos_i,
  input  logic [2:0][31:0]    inv_i,
  output logic                valid_o,
  output enr_pkg::sqrt_t      data_o
);

  localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int SH = 32 - CW;
  localparam logic [63:0] POS_LIM = (64'd1 << (CW - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'd1 << (CW - 1);
  localparam logic [63:0] ONE_Q16 = 64'd65536;
  localparam int NSTG = 11;

  logic vld_q [1:NSTG];

  // stage 1: sign and magnitude of the coordinates
  logic [2:0]       neg1_q;
  logic [2:0][31:0] mag1_q;
  // stage 2: gradient products and squares
  logic [2:0]       neg2_q;
  logic [2:0][63:0] m2_q;
  logic [2:0][63:0] sq2_q;
  // stage 3: residual partial products
  logic [2:0][63:0] phi3_q;
  logic [2:0][63:0] plo3_q;
  // stage 4 and 5: residual sum
  logic [2:0][63:0] term4_q;
  logic [63:0]      sum5_q;
  // normalizing shifter
  logic [2:0][63:0] nm_q  [0:6];
  logic [63:0]      nmx_q [0:6];
  // stage 10 and 11: squared magnitudes
  logic [2:0][30:0] v10_q;
  logic [2:0][61:0] vsq10_q;
  logic [2:0][30:0] v11_q;
  logic [63:0]      sumsq11_q;

  enr_pkg::side_t side_q [3:NSTG];

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NSTG; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[1] <= valid_i;
      for (int k = 2; k <= NSTG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [31:0] sx;
      sx = $signed(pos_i[i] << SH) >>> SH;
      neg1_q[i] <= sx[31];
      mag1_q[i] <= sx[31] ? (~sx + 32'd1) : sx;
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic [63:0] p;
      p = 64'(mag1_q[i]) * 64'(inv_i[i]);
      m2_q[i]  <= {p[62:0], 1'b0};
      sq2_q[i] <= 64'(mag1_q[i]) * 64'(mag1_q[i]);
    end
    neg2_q <= neg1_q;
  end

  // stage 3: saturate gradient, find largest magnitude
  enr_pkg::side_t side3_d;
  logic [63:0]    mx3_d;
  always_comb begin
    logic [47:0] g;
    logic [63:0] lim;
    side3_d = '0;
    side3_d.neg = neg2_q;
    for (int i = 0; i < 3; i++) begin
      g   = m2_q[i][63:16];
      lim = neg2_q[i] ? NEG_LIM : POS_LIM;
      if ({16'd0, g} > lim) begin
        g = lim[47:0];
        side3_d.sat = 1'b1;
      end
      side3_d.grad[i] = neg2_q[i] ? (32'd0 - g[31:0]) : g[31:0];
    end
    mx3_d = m2_q[0];
    if (m2_q[1] > mx3_d) mx3_d = m2_q[1];
    if (m2_q[2] > mx3_d) mx3_d = m2_q[2];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      phi3_q[i] <= 64'(sq2_q[i][63:32]) * 64'(inv_i[i]);
      plo3_q[i] <= 64'(sq2_q[i][31:0]) * 64'(inv_i[i]);
    end
    nm_q[0]   <= m2_q;
    nmx_q[0]  <= mx3_d;
    side_q[3] <= side3_d;
  end

  // stage 4: per-axis squared terms, zero gradient check
  always_ff @(posedge clk_i) begin
    enr_pkg::side_t s4;
    for (int i = 0; i < 3; i++) begin
      term4_q[i] <= phi3_q[i] + {32'd0, plo3_q[i][63:32]};
    end
    s4       = side_q[3];
    s4.degen = (nmx_q[0] == 64'd0);
    side_q[4] <= s4;
  end

  // stage 5: sum of terms
  always_ff @(posedge clk_i) begin
    sum5_q    <= term4_q[0] + term4_q[1] + term4_q[2];
    side_q[5] <= side_q[4];
  end

  // stage 6: subtract one and saturate the residual
  always_ff @(posedge clk_i) begin
    logic [63:0]    d;
    enr_pkg::side_t s6;
    s6 = side_q[5];
    if (sum5_q >= ONE_Q16) begin
      d = sum5_q - ONE_Q16;
      if (d > POS_LIM) begin
        d      = POS_LIM;
        s6.sat = 1'b1;
      end
      s6.residual = d[31:0];
    end else begin
      d = ONE_Q16 - sum5_q;
      if (d > NEG_LIM) begin
        d      = NEG_LIM;
        s6.sat = 1'b1;
      end
      s6.residual = 32'd0 - d[31:0];
    end
    side_q[6] <= s6;
  end

  // side pipe through the remaining stages
  for (genvar k = 7; k <= NSTG; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // left-normalize so the largest magnitude reaches bit 63, one shift size per stage
  for (genvar k = 0; k < 6; k++) begin : g_norm
    localparam int S = 32 >> k;
    always_ff @(posedge clk_i) begin
      if (nmx_q[k][63 -: S] == '0) begin
        nmx_q[k+1] <= nmx_q[k] << S;
        for (int i = 0; i < 3; i++) nm_q[k+1][i] <= nm_q[k][i] << S;
      end else begin
        nmx_q[k+1] <= nmx_q[k];
        nm_q[k+1]  <= nm_q[k];
      end
    end
  end

  // stage 10: top bit at 30, square each component
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      v10_q[i]   <= nm_q[6][i][63:33];
      vsq10_q[i] <= 62'(nm_q[6][i][63:33]) * 62'(nm_q[6][i][63:33]);
    end
  end

  // stage 11: sum of squares
  always_ff @(posedge clk_i) begin
    v11_q     <= v10_q;
    sumsq11_q <= 64'(vsq10_q[0]) + 64'(vsq10_q[1]) + 64'(vsq10_q[2]);
  end

  assign valid_o      = vld_q[NSTG];
  assign data_o.rad   = sumsq11_q;
  assign data_o.rem   = '0;
  assign data_o.root  = '0;
  assign data_o.v     = v11_q;
  assign data_o.side  = side_q[NSTG];

endmodule

/* hdl/enr_sqrt_cell.sv */
// One digit step of the integer square root: two radicand bits in, one root bit out.
// Depends on enr_pkg for the cell word.
module enr_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  enr_pkg::sqrt_t data_i,
  output logic           valid_o,
  output enr_pkg::sqrt_t data_o
);

  logic           valid_q;
  enr_pkg::sqrt_t data_q;
  enr_pkg::sqrt_t data_d;

  // trial subtract of 4*root+1
  always_comb begin
    logic [34:0] rem_n;
    logic [34:0] trial;
    data_d     = data_i;
    rem_n      = {data_i.rem[32:0], data_i.rad[63:62]};
    trial      = {1'b0, data_i.root, 2'b01};
    data_d.rad = {data_i.rad[61:0], 2'b00};
    if (rem_n >= trial) begin
      data_d.rem  = rem_n - trial;
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = rem_n;
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/enr_div_cell.sv */
// One restoring division step for the three normal components.
// Depends on enr_pkg for the cell word.
module enr_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  enr_pkg::div_t data_i,
  output logic          valid_o,
  output enr_pkg::div_t data_o
);

  logic          valid_q;
  enr_pkg::div_t data_q;
  enr_pkg::div_t data_d;

  // shift in one numerator bit, subtract the length when it fits
  always_comb begin
    logic [32:0] rem_n;
    logic [32:0] diff;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      rem_n = {data_i.rem[i], data_i.numlo[i][31]};
      diff  = rem_n - {1'b0, data_i.len};
      data_d.numlo[i] = {data_i.numlo[i][30:0], 1'b0};
      if (rem_n >= {1'b0, data_i.len}) begin
        data_d.rem[i] = diff[31:0];
        data_d.quo[i] = {data_i.quo[i][30:0], 1'b1};
      end else begin
        data_d.rem[i] = rem_n[31:0];
        data_d.quo[i] = {data_i.quo[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
